FILE: rtl/fac_pkg.sv
// Shared constants and types for the fuzzy attribute closure block.
package fac_pkg;

  localparam int MAX_OBJECTS = 64;
  localparam int MAX_ATTRS = 32;
  localparam int DEGREE_BITS = 8;

  localparam int OBJ_W = $clog2(MAX_OBJECTS);
  localparam int ATTR_W = $clog2(MAX_ATTRS);
  localparam int ROW_W = MAX_ATTRS * DEGREE_BITS;
  localparam int TREE_LEVELS = ATTR_W;

  localparam int NUM_OBJECTS_W = 7;
  localparam int NUM_ATTRS_W = 6;
  localparam int CFG_DATA_W = 7;
  localparam logic [NUM_OBJECTS_W-1:0] NUM_OBJECTS_RESET = NUM_OBJECTS_W'(MAX_OBJECTS);
  localparam logic [NUM_ATTRS_W-1:0] NUM_ATTRS_RESET = NUM_ATTRS_W'(MAX_ATTRS);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    REG_NUM_OBJECTS = 1'b0,
    REG_NUM_ATTRS   = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX,
    ST_MAX_END,
    ST_DOM,
    ST_DOM_END
  } state_t;

endpackage

FILE: rtl/fuzzy_attribute_closure.sv
// Top level of the fuzzy attribute closure block: context memory, sequencer and result path.
//
// A command is accepted at a rising edge where start is high and busy is low.
// operation selects a cell load or a closure query. A load writes one degree
// into the row-organized context memory in that cycle and causes no result;
// busy stays low, so loads may follow one another in every cycle.
// A query raises busy and walks the rows in use twice through one shared
// row unit: the first pass forms each object's extent degree with a max tree
// and keeps it in a small extent memory, the second pass compares each row
// against its extent and narrows the closed attribute set. One row word is
// read per cycle through the single read port of the context memory. The
// results come out of the second pass, one beat per object in object order,
// each beat high on result_valid for one cycle; the beat with last high carries
// the closed mask. The receiver cannot stall, so beats are never held. The
// configuration channel is always ready; the user must see that it is written
// only while busy is low, unenforced by the block. Reset returns the sequencer
// to idle, drops any pending beat and restores both register defaults; the
// context memory needs no clearing pass and holds anything until it is loaded.
module fuzzy_attribute_closure (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 operation,
  input  logic [fac_pkg::OBJ_W-1:0]            object_index,
  input  logic [fac_pkg::ATTR_W-1:0]           attr_index,
  input  logic [fac_pkg::DEGREE_BITS-1:0]      degree,
  input  logic [fac_pkg::MAX_ATTRS-1:0]        attr_mask,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [fac_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 result_valid,
  output logic [fac_pkg::OBJ_W-1:0]            result_object,
  output logic [fac_pkg::DEGREE_BITS-1:0]      extent_degree,
  output logic [fac_pkg::MAX_ATTRS-1:0]        closed_mask,
  output logic                                 last
);

  logic [fac_pkg::ROW_W-1:0]         ctx_mem [fac_pkg::MAX_OBJECTS];
  logic [fac_pkg::DEGREE_BITS-1:0]   ext_mem [fac_pkg::MAX_OBJECTS];

  logic [fac_pkg::NUM_OBJECTS_W-1:0] num_objects;
  logic [fac_pkg::NUM_ATTRS_W-1:0]   num_attrs;

  fac_pkg::state_t                   state, state_next;
  logic [fac_pkg::OBJ_W-1:0]         obj_cnt, obj_cnt_next;
  logic [fac_pkg::OBJ_W-1:0]         obj_last;
  logic [fac_pkg::MAX_ATTRS-1:0]     sel_mask;
  logic [fac_pkg::MAX_ATTRS-1:0]     use_mask;
  logic [fac_pkg::MAX_ATTRS-1:0]     closed;

  logic                              issue;
  logic                              issue_dom;
  logic                              query_go;
  logic                              load_go;

  logic                              rd_valid;
  logic                              rd_dom;
  logic                              rd_last;
  logic [fac_pkg::OBJ_W-1:0]         rd_obj;
  logic [fac_pkg::ROW_W-1:0]         row_q;
  logic [fac_pkg::DEGREE_BITS-1:0]   ext_q;

  logic [fac_pkg::OBJ_W-1:0]         obj_last_in;
  logic [fac_pkg::MAX_ATTRS-1:0]     use_mask_in;
  logic [fac_pkg::DEGREE_BITS-1:0]   tree [fac_pkg::TREE_LEVELS+1][fac_pkg::MAX_ATTRS];
  logic [fac_pkg::DEGREE_BITS-1:0]   row_max;
  logic [fac_pkg::MAX_ATTRS-1:0]     viol;

  assign busy      = (state != fac_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign query_go  = start && !busy && (operation == fac_pkg::OP_QUERY);
  assign load_go   = start && !busy && (operation == fac_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_objects <= fac_pkg::NUM_OBJECTS_RESET;
      num_attrs   <= fac_pkg::NUM_ATTRS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (fac_pkg::reg_index_t'(cfg_index))
        fac_pkg::REG_NUM_OBJECTS: num_objects <= cfg_data;
        fac_pkg::REG_NUM_ATTRS:   num_attrs   <= cfg_data[fac_pkg::NUM_ATTRS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_objects == '0) begin
      obj_last_in = '0;
    end else if (num_objects > fac_pkg::NUM_OBJECTS_W'(fac_pkg::MAX_OBJECTS)) begin
      obj_last_in = fac_pkg::OBJ_W'(fac_pkg::MAX_OBJECTS - 1);
    end else begin
      obj_last_in = fac_pkg::OBJ_W'(num_objects - 1'b1);
    end
    for (int a = 0; a < fac_pkg::MAX_ATTRS; a++) begin
      use_mask_in[a] = (num_attrs == '0) ? (a == 0)
                     : (fac_pkg::NUM_ATTRS_W'(a) < num_attrs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fac_pkg::ST_IDLE;
      obj_cnt <= '0;
    end else begin
      state   <= state_next;
      obj_cnt <= obj_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    obj_cnt_next = obj_cnt;
    issue        = 1'b0;
    issue_dom    = 1'b0;
    case (state)
      fac_pkg::ST_IDLE: begin
        if (query_go) begin
          state_next   = fac_pkg::ST_MAX;
          obj_cnt_next = '0;
        end
      end
      fac_pkg::ST_MAX: begin
        issue = 1'b1;
        if (obj_cnt == obj_last) begin
          state_next   = fac_pkg::ST_MAX_END;
          obj_cnt_next = '0;
        end else begin
          obj_cnt_next = obj_cnt + 1'b1;
        end
      end
      fac_pkg::ST_MAX_END: begin
        state_next = fac_pkg::ST_DOM;
      end
      fac_pkg::ST_DOM: begin
        issue     = 1'b1;
        issue_dom = 1'b1;
        if (obj_cnt == obj_last) begin
          state_next   = fac_pkg::ST_DOM_END;
          obj_cnt_next = '0;
        end else begin
          obj_cnt_next = obj_cnt + 1'b1;
        end
      end
      fac_pkg::ST_DOM_END: begin
        state_next = fac_pkg::ST_IDLE;
      end
      default: begin
        state_next = fac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      sel_mask <= attr_mask;
      use_mask <= use_mask_in;
      obj_last <= obj_last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      ctx_mem[object_index][attr_index*fac_pkg::DEGREE_BITS +: fac_pkg::DEGREE_BITS] <= degree;
    end
    row_q <= ctx_mem[obj_cnt];
  end

  always_ff @(posedge clk) begin
    if (rd_valid && !rd_dom) begin
      ext_mem[rd_obj] <= row_max;
    end
    ext_q <= ext_mem[obj_cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
    rd_dom  <= issue_dom;
    rd_last <= (obj_cnt == obj_last);
    rd_obj  <= obj_cnt;
  end

  always_comb begin
    for (int l = 0; l <= fac_pkg::TREE_LEVELS; l++) begin
      for (int i = 0; i < fac_pkg::MAX_ATTRS; i++) begin
        tree[l][i] = '0;
      end
    end
    for (int a = 0; a < fac_pkg::MAX_ATTRS; a++) begin
      tree[0][a] = (sel_mask[a] && use_mask[a])
                 ? row_q[a*fac_pkg::DEGREE_BITS +: fac_pkg::DEGREE_BITS] : '0;
    end
    for (int l = 0; l < fac_pkg::TREE_LEVELS; l++) begin
      for (int i = 0; i < (fac_pkg::MAX_ATTRS >> (l + 1)); i++) begin
        tree[l+1][i] = (tree[l][2*i] > tree[l][2*i+1]) ? tree[l][2*i] : tree[l][2*i+1];
      end
    end
    row_max = tree[fac_pkg::TREE_LEVELS][0];
    for (int a = 0; a < fac_pkg::MAX_ATTRS; a++) begin
      viol[a] = row_q[a*fac_pkg::DEGREE_BITS +: fac_pkg::DEGREE_BITS] > ext_q;
    end
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      closed <= use_mask_in;
    end else if (rd_valid && rd_dom) begin
      closed <= closed & ~viol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= rd_valid && rd_dom;
    end
    result_object <= rd_obj;
    extent_degree <= ext_q;
    closed_mask   <= rd_last ? (closed & ~viol) : '0;
    last          <= rd_last;
  end

endmodule

FILE: rtl/fac_checker.sv
// Port-level checker for the fuzzy attribute closure block and its bind.
module fac_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                operation,
  input logic                                result_valid,
  input logic [fac_pkg::OBJ_W-1:0]           result_object,
  input logic [fac_pkg::MAX_ATTRS-1:0]       closed_mask,
  input logic                                last
);

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("Result beat before the last one while the block is idle.");

  a_mid_mask_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> (closed_mask == '0))
    else $error("Closed mask is nonzero on a beat that is not the last.");

  a_beats_in_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=>
      (result_valid && (result_object == fac_pkg::OBJ_W'($past(result_object) + 1'b1))))
    else $error("Result beats are not contiguous in object order.");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == fac_pkg::OP_LOAD)) |=> !result_valid)
    else $error("A cell load produced a result beat.");

endmodule

bind fuzzy_attribute_closure fac_checker u_fac_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .operation     (operation),
  .result_valid  (result_valid),
  .result_object (result_object),
  .closed_mask   (closed_mask),
  .last          (last)
);

FILE: dv/fuzzy_attribute_closure_tb.sv
// Self-checking testbench for the fuzzy attribute closure block with a built-in closure predictor.
`timescale 1ns / 1ps

module fuzzy_attribute_closure_tb;

  localparam int FILL_ROWS = 8;

  typedef struct packed {
    fac_pkg::op_t                    op;
    logic [fac_pkg::OBJ_W-1:0]       row;
    logic [fac_pkg::ATTR_W-1:0]      col;
    logic [fac_pkg::DEGREE_BITS-1:0] level;
    logic [fac_pkg::MAX_ATTRS-1:0]   mask;
  } closure_cmd_t;

  typedef struct packed {
    logic [fac_pkg::OBJ_W-1:0]       obj;
    logic [fac_pkg::DEGREE_BITS-1:0] extent;
    logic [fac_pkg::MAX_ATTRS-1:0]   closed;
    logic                            is_last;
  } closure_beat_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  logic                            operation = fac_pkg::OP_LOAD;
  logic [fac_pkg::OBJ_W-1:0]       object_index = '0;
  logic [fac_pkg::ATTR_W-1:0]      attr_index = '0;
  logic [fac_pkg::DEGREE_BITS-1:0] degree = '0;
  logic [fac_pkg::MAX_ATTRS-1:0]   attr_mask = '0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_index = fac_pkg::REG_NUM_OBJECTS;
  logic [fac_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            result_valid;
  logic [fac_pkg::OBJ_W-1:0]       result_object;
  logic [fac_pkg::DEGREE_BITS-1:0] extent_degree;
  logic [fac_pkg::MAX_ATTRS-1:0]   closed_mask;
  logic                            last;

  closure_cmd_t  cmd_q [$];
  closure_beat_t beat_q [$];
  closure_cmd_t  next_cmd;
  closure_beat_t want;

  logic [fac_pkg::DEGREE_BITS-1:0]   ctx_model [fac_pkg::MAX_OBJECTS][fac_pkg::MAX_ATTRS];
  logic [fac_pkg::NUM_OBJECTS_W-1:0] nobj_cfg;
  logic [fac_pkg::NUM_ATTRS_W-1:0]   nattr_cfg;

  logic cmd_taken = 1'b0;
  logic cfg_taken = 1'b0;
  bit   calm_phase = 1'b0;
  int   idle_left = 0;
  int   error_count = 0;
  int   loads_seen = 0;
  int   queries_seen = 0;
  int   beats_seen = 0;
  int   reg_writes = 0;

  fuzzy_attribute_closure uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .object_index (object_index),
    .attr_index   (attr_index),
    .degree       (degree),
    .attr_mask    (attr_mask),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_object(result_object),
    .extent_degree(extent_degree),
    .closed_mask  (closed_mask),
    .last         (last)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void predict_closure(input logic [fac_pkg::MAX_ATTRS-1:0] sel);
    int n;
    int m;
    logic [fac_pkg::DEGREE_BITS-1:0] ext [fac_pkg::MAX_OBJECTS];
    logic [fac_pkg::MAX_ATTRS-1:0] closed;
    closure_beat_t beat;
    n = (nobj_cfg == 0) ? 1 : (nobj_cfg > fac_pkg::MAX_OBJECTS) ? fac_pkg::MAX_OBJECTS
                                                                 : int'(nobj_cfg);
    m = (nattr_cfg == 0) ? 1 : (nattr_cfg > fac_pkg::MAX_ATTRS) ? fac_pkg::MAX_ATTRS
                                                                : int'(nattr_cfg);
    for (int o = 0; o < n; o++) begin
      ext[o] = '0;
      for (int a = 0; a < m; a++) begin
        if (sel[a] && ctx_model[o][a] > ext[o]) ext[o] = ctx_model[o][a];
      end
    end
    closed = '0;
    for (int a = 0; a < m; a++) begin
      closed[a] = 1'b1;
      for (int o = 0; o < n; o++) begin
        if (ctx_model[o][a] > ext[o]) closed[a] = 1'b0;
      end
    end
    for (int o = 0; o < n; o++) begin
      beat.obj = fac_pkg::OBJ_W'(o);
      beat.extent = ext[o];
      beat.is_last = (o == n - 1);
      beat.closed = beat.is_last ? closed : '0;
      beat_q = {beat_q, beat};
    end
  endfunction

  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_phase || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else if (!start || cmd_taken) begin
      if (idle_left != 0 || cmd_q.size() == 0) begin
        start <= 1'b0;
        if (idle_left != 0) idle_left <= idle_left - 1;
      end else begin
        next_cmd = cmd_q.pop_front();
        operation <= next_cmd.op;
        object_index <= next_cmd.row;
        attr_index <= next_cmd.col;
        degree <= next_cmd.level;
        attr_mask <= next_cmd.mask;
        start <= 1'b1;
        idle_left <= pick_idle();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cmd_taken <= 1'b0;
      cfg_taken <= 1'b0;
      nobj_cfg = fac_pkg::NUM_OBJECTS_RESET;
      nattr_cfg = fac_pkg::NUM_ATTRS_RESET;
    end else begin
      cmd_taken <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
      if (result_valid) begin
        if (beat_q.size() == 0) begin
          report_mismatch($sformatf("beat for object %0d with nothing expected", result_object));
        end else begin
          want = beat_q.pop_front();
          beats_seen++;
          if (result_object !== want.obj)
            report_mismatch($sformatf("result_object %0d, expected %0d", result_object, want.obj));
          if (extent_degree !== want.extent)
            report_mismatch($sformatf("object %0d extent_degree %0d, expected %0d",
                                      want.obj, extent_degree, want.extent));
          if (closed_mask !== want.closed)
            report_mismatch($sformatf("object %0d closed_mask %h, expected %h",
                                      want.obj, closed_mask, want.closed));
          if (last !== want.is_last)
            report_mismatch($sformatf("object %0d last %b, expected %b",
                                      want.obj, last, want.is_last));
        end
      end
      if (start && !busy) begin
        if (operation == fac_pkg::OP_LOAD) begin
          ctx_model[object_index][attr_index] = degree;
          loads_seen++;
        end else begin
          predict_closure(attr_mask);
          queries_seen++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (fac_pkg::reg_index_t'(cfg_index))
          fac_pkg::REG_NUM_OBJECTS: nobj_cfg = cfg_data[fac_pkg::NUM_OBJECTS_W-1:0];
          fac_pkg::REG_NUM_ATTRS: nattr_cfg = cfg_data[fac_pkg::NUM_ATTRS_W-1:0];
          default: ;
        endcase
        reg_writes++;
      end
    end
  end

  function automatic logic [fac_pkg::DEGREE_BITS-1:0] random_level();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return '0;
    if (roll == 3) return '1;
    if (roll < 7) return fac_pkg::DEGREE_BITS'($urandom_range(0, 7));
    return fac_pkg::DEGREE_BITS'($urandom_range(0, 255));
  endfunction

  function automatic logic [fac_pkg::MAX_ATTRS-1:0] random_mask(input int cols);
    logic [fac_pkg::MAX_ATTRS-1:0] one_hot;
    one_hot = 1;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return one_hot << $urandom_range(0, cols - 1);
      3: return $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_load(input int row, input int col,
                            input logic [fac_pkg::DEGREE_BITS-1:0] level);
    closure_cmd_t cmd;
    cmd.op = fac_pkg::OP_LOAD;
    cmd.row = fac_pkg::OBJ_W'(row);
    cmd.col = fac_pkg::ATTR_W'(col);
    cmd.level = level;
    cmd.mask = '0;
    cmd_q = {cmd_q, cmd};
  endtask

  task automatic queue_query(input logic [fac_pkg::MAX_ATTRS-1:0] sel);
    closure_cmd_t cmd;
    cmd.op = fac_pkg::OP_QUERY;
    cmd.row = '0;
    cmd.col = '0;
    cmd.level = '0;
    cmd.mask = sel;
    cmd_q = {cmd_q, cmd};
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (cmd_q.size() != 0 || start || busy || beat_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input fac_pkg::reg_index_t idx, input int value);
    repeat ($urandom_range(0, 3)) @(negedge clk);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= fac_pkg::CFG_DATA_W'(value);
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int obj_setting, input int attr_setting, input int count,
                           input bit calm);
    int rows;
    int cols;
    write_reg(fac_pkg::REG_NUM_OBJECTS, obj_setting);
    write_reg(fac_pkg::REG_NUM_ATTRS, attr_setting);
    rows = (obj_setting < 1) ? 1 : (obj_setting > fac_pkg::MAX_OBJECTS) ? fac_pkg::MAX_OBJECTS
                                                                        : obj_setting;
    cols = (attr_setting < 1) ? 1 : (attr_setting > fac_pkg::MAX_ATTRS) ? fac_pkg::MAX_ATTRS
                                                                        : attr_setting;
    calm_phase = calm;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_query(random_mask(cols));
      end else if ($urandom_range(0, 6) == 0) begin
        queue_load($urandom_range(0, fac_pkg::MAX_OBJECTS - 1),
                   $urandom_range(0, fac_pkg::MAX_ATTRS - 1), random_level());
      end else begin
        queue_load($urandom_range(0, rows - 1), $urandom_range(0, cols - 1), random_level());
      end
      if ($urandom_range(0, 49) == 0) wait_idle();
    end
    wait_idle();
    calm_phase = 1'b0;
  endtask

  initial begin
    int guard;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Column zero of every row and every column of the first rows are loaded
    // before any query, and no query reaches past them.
    for (int r = 0; r < fac_pkg::MAX_OBJECTS; r++) queue_load(r, 0, random_level());
    for (int r = 0; r < FILL_ROWS; r++) begin
      for (int c = 1; c < fac_pkg::MAX_ATTRS; c++) queue_load(r, c, random_level());
    end
    wait_idle();

    write_reg(fac_pkg::REG_NUM_OBJECTS, FILL_ROWS);
    write_reg(fac_pkg::REG_NUM_ATTRS, fac_pkg::MAX_ATTRS);
    queue_query('0);
    queue_query('1);
    queue_query(32'h0000_0001);
    queue_query(32'h8000_0000);
    queue_load(0, 0, 8'h00);
    queue_load(fac_pkg::MAX_OBJECTS - 1, fac_pkg::MAX_ATTRS - 1, 8'hFF);
    queue_query(32'h8000_0001);
    wait_idle();

    // An all-zero column joins the closed set of an empty selection.
    write_reg(fac_pkg::REG_NUM_OBJECTS, 3);
    write_reg(fac_pkg::REG_NUM_ATTRS, 4);
    queue_load(0, 1, 8'h00);
    queue_load(1, 1, 8'h00);
    queue_load(2, 1, 8'h00);
    queue_query('0);
    queue_query(32'hFFFF_FFF0);
    queue_query(32'h0000_0002);
    wait_idle();

    write_reg(fac_pkg::REG_NUM_OBJECTS, 0);
    write_reg(fac_pkg::REG_NUM_ATTRS, 0);
    queue_query('1);
    queue_query('0);
    wait_idle();

    write_reg(fac_pkg::REG_NUM_OBJECTS, 127);
    write_reg(fac_pkg::REG_NUM_ATTRS, 1);
    queue_query(32'h5555_5555);
    wait_idle();

    write_reg(fac_pkg::REG_NUM_OBJECTS, 2);
    write_reg(fac_pkg::REG_NUM_ATTRS, 63);
    queue_query(32'h5555_5555);
    wait_idle();

    run_phase(2, 3, 30, 1'b0);
    run_phase(1, 1, 15, 1'b1);
    run_phase(0, 7, 15, 1'b0);
    run_phase(5, 7, 20, 1'b0);
    run_phase(FILL_ROWS, 32, 25, 1'b1);
    run_phase(64, 1, 20, 1'b0);
    run_phase(127, 1, 10, 1'b0);
    run_phase(2, 63, 15, 1'b0);

    do @(negedge clk); while (cmd_q.size() != 0 || start);
    guard = 0;
    while ((busy || beat_q.size() != 0) && guard < 4000) begin
      @(negedge clk);
      guard++;
    end
    repeat (16) @(negedge clk);
    if (beat_q.size() != 0)
      report_mismatch($sformatf("%0d expected result beats never arrived", beat_q.size()));

    $display("Run covered %0d cell loads, %0d closure queries and %0d result beats,",
             loads_seen, queries_seen, beats_seen);
    $display("with %0d register writes across saturated, minimal and full-height contexts.",
             reg_writes);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
